@@ design/fcsm_pkg.sv @@
package fcsm_pkg;

  localparam int PAGE_COUNT = 1024;
  localparam int PAGE_W     = 10;

  typedef enum logic [1:0] {
    OP_CMD_WRITE   = 2'd0,
    OP_STATUS_READ = 2'd1,
    OP_DMA_OUT     = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_ERASE   = 2'd1,
    ACT_PROGRAM = 2'd2,
    ACT_DUMP    = 2'd3
  } act_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'd0,
    S_E1   = 4'd1,
    S_E2   = 4'd2,
    S_ERS1 = 4'd3,
    S_ERS2 = 4'd4,
    S_WI   = 4'd5,
    S_WSP  = 4'd6,
    S_WRS1 = 4'd7,
    S_WRS2 = 4'd8,
    S_GSI  = 4'd9,
    S_GS1  = 4'd10,
    S_RI   = 4'd11,
    S_RRS1 = 4'd12
  } state_t;

  localparam logic [15:0] C_NULL    = 16'h0000;
  localparam logic [15:0] C_ERASE1  = 16'h4B00;
  localparam logic [15:0] C_ERASE2  = 16'h7800;
  localparam logic [15:0] C_EXEC    = 16'hD200;
  localparam logic [15:0] C_WINIT   = 16'hB400;
  localparam logic [15:0] C_SETPAGE = 16'hA500;
  localparam logic [15:0] C_GETSTAT = 16'hE100;
  localparam logic [15:0] C_RINIT   = 16'hF000;

  localparam logic [31:0] ST_ERASE = 32'h11118008;
  localparam logic [31:0] ST_WRITE = 32'h11118004;
  localparam logic [31:0] ST_GET   = 32'h11118001;
  localparam logic [31:0] ST_READ  = 32'h11118004;
  localparam logic [31:0] ST_TWO   = 32'h00C20000;
  localparam logic [31:0] ST_READ2 = 32'hF0000000;

  localparam logic [31:0] DMA_STATUS_ADDR = 32'hA8000000;

  typedef struct packed {
    op_t         opcode;
    logic [31:0] command_word;
    logic [31:0] dma_flash_address;
  } cmd_t;

  typedef struct packed {
    logic [31:0]       status_data;
    act_t              action;
    logic [PAGE_W-1:0] action_page;
    logic              error;
  } rsp_t;

endpackage

@@ design/flash_command_state_machine.sv @@
// Flash save chip command sequencer.
//
// cmd channel: one word per bus access. opcode selects a command write
// (command_word: code in bits 31..16, page in bits 15..0), a status read,
// or the notice of a DMA out of flash (dma_flash_address).
// rsp channel: exactly one word per cmd word, in order: status_data on a
// status read, an erase / program action with its page or a dump action,
// and an error flag when the sequence was broken and the machine fell to idle.
//
// A cmd word is taken into the input register and stepped through the
// sequencer from there; its rsp word and rsp_valid are registered together.
// Throughput: one word per cycle while rsp does not stall, set by the single
// decode step between the input register and the result register.
//
// Reset (rst, synchronous): sequencer idle, status word 0x11118001,
// shadow status, page and reading mode cleared, both registers empty.
// A stall on rsp holds the result register; the input register then fills
// and cmd_stall rises until rsp drains.
module flash_command_state_machine (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  fcsm_pkg::cmd_t    cmd,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output fcsm_pkg::rsp_t    rsp
);

  logic                        in_valid;
  fcsm_pkg::cmd_t              in_word;
  logic                        advance;
  logic                        fire;

  fcsm_pkg::state_t            state, state_next;
  logic [31:0]                 status_word, status_word_next;
  logic [31:0]                 shadow_status, shadow_status_next;
  logic [fcsm_pkg::PAGE_W-1:0] page, page_next;
  logic                        read_mode, read_mode_next;

  logic [15:0]                 code;
  logic [fcsm_pkg::PAGE_W-1:0] cmd_page;
  logic                        run_step;
  logic                        dma_kick;
  logic                        ok;
  fcsm_pkg::rsp_t              rsp_next;

  assign advance   = !rsp_valid || !rsp_stall;
  assign fire      = in_valid && advance;
  assign cmd_stall = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!cmd_stall) begin
      in_valid <= cmd_valid;
    end
    if (cmd_valid && !cmd_stall) begin
      in_word <= cmd;
    end
  end

  // Status reads step the machine with a null event, except in reading mode.
  assign code = (in_word.opcode == fcsm_pkg::OP_CMD_WRITE) ?
                in_word.command_word[31:16] : fcsm_pkg::C_NULL;
  // Page count is a power of two: keep the low page bits.
  assign cmd_page = in_word.command_word[fcsm_pkg::PAGE_W-1:0];
  assign run_step = (in_word.opcode == fcsm_pkg::OP_CMD_WRITE) ||
                    (in_word.opcode == fcsm_pkg::OP_STATUS_READ && !read_mode);
  assign dma_kick = (in_word.opcode == fcsm_pkg::OP_DMA_OUT) &&
                    (in_word.dma_flash_address == fcsm_pkg::DMA_STATUS_ADDR);

  // Next state
  always_comb begin
    state_next         = state;
    status_word_next   = status_word;
    shadow_status_next = shadow_status;
    page_next          = page;
    read_mode_next     = read_mode;
    ok                 = 1'b0;
    if (dma_kick) begin
      status_word_next   = fcsm_pkg::ST_GET;
      shadow_status_next = fcsm_pkg::ST_TWO;
      state_next         = fcsm_pkg::S_GS1;
    end else if (run_step) begin
      case (state)
        fcsm_pkg::S_IDLE: begin
          ok = 1'b1;
          case (code)
            fcsm_pkg::C_ERASE1: begin
              page_next  = cmd_page;
              state_next = fcsm_pkg::S_E1;
            end
            fcsm_pkg::C_WINIT: state_next = fcsm_pkg::S_WI;
            fcsm_pkg::C_GETSTAT: begin
              state_next         = fcsm_pkg::S_GSI;
              shadow_status_next = fcsm_pkg::ST_GET;
            end
            fcsm_pkg::C_RINIT: state_next = fcsm_pkg::S_RI;
            fcsm_pkg::C_NULL: begin
              status_word_next   = fcsm_pkg::ST_GET;
              shadow_status_next = fcsm_pkg::ST_TWO;
              state_next         = fcsm_pkg::S_GS1;
            end
            fcsm_pkg::C_EXEC: ok = 1'b1;
            default: ok = 1'b0;
          endcase
        end
        fcsm_pkg::S_E1: begin
          if (code == fcsm_pkg::C_ERASE2) begin
            ok = 1'b1;
            state_next = fcsm_pkg::S_E2;
          end
        end
        fcsm_pkg::S_E2: begin
          if (code == fcsm_pkg::C_NULL) begin
            ok = 1'b1;
            status_word_next = fcsm_pkg::ST_ERASE;
            state_next       = fcsm_pkg::S_ERS1;
          end else if (code == fcsm_pkg::C_EXEC) begin
            ok = 1'b1;
            state_next = fcsm_pkg::S_IDLE;
          end
        end
        fcsm_pkg::S_ERS1: begin
          if (code == fcsm_pkg::C_NULL) begin
            ok = 1'b1;
            status_word_next = fcsm_pkg::ST_TWO;
            state_next       = fcsm_pkg::S_ERS2;
          end
        end
        fcsm_pkg::S_ERS2: begin
          if (code == fcsm_pkg::C_EXEC) begin
            ok = 1'b1;
            state_next = fcsm_pkg::S_IDLE;
          end
        end
        fcsm_pkg::S_WI: begin
          if (code == fcsm_pkg::C_SETPAGE) begin
            ok = 1'b1;
            page_next  = cmd_page;
            state_next = fcsm_pkg::S_WSP;
          end else if (code == fcsm_pkg::C_WINIT) begin
            ok = 1'b1;
          end
        end
        fcsm_pkg::S_WSP: begin
          if (code == fcsm_pkg::C_NULL) begin
            ok = 1'b1;
            status_word_next = fcsm_pkg::ST_WRITE;
            state_next       = fcsm_pkg::S_WRS1;
          end else if (code == fcsm_pkg::C_WINIT) begin
            ok = 1'b1;
          end
        end
        fcsm_pkg::S_WRS1: begin
          if (code == fcsm_pkg::C_NULL) begin
            ok = 1'b1;
            status_word_next = fcsm_pkg::ST_TWO;
            state_next       = fcsm_pkg::S_WRS2;
          end
        end
        fcsm_pkg::S_WRS2: begin
          if (code == fcsm_pkg::C_NULL) begin
            ok = 1'b1;
            status_word_next = fcsm_pkg::ST_WRITE;
            state_next       = fcsm_pkg::S_WRS1;
          end else if (code == fcsm_pkg::C_EXEC) begin
            ok = 1'b1;
            state_next = fcsm_pkg::S_IDLE;
          end
        end
        fcsm_pkg::S_GSI: begin
          ok = 1'b1;
          case (code)
            fcsm_pkg::C_NULL: begin
              status_word_next = fcsm_pkg::ST_GET;
              state_next       = fcsm_pkg::S_GS1;
            end
            fcsm_pkg::C_EXEC:  state_next = fcsm_pkg::S_IDLE;
            fcsm_pkg::C_RINIT: state_next = fcsm_pkg::S_RI;
            default: ok = 1'b0;
          endcase
        end
        fcsm_pkg::S_GS1: begin
          ok = 1'b1;
          case (code)
            fcsm_pkg::C_NULL: begin
              status_word_next = fcsm_pkg::ST_TWO;
              state_next       = fcsm_pkg::S_IDLE;
            end
            fcsm_pkg::C_EXEC:    state_next = fcsm_pkg::S_IDLE;
            fcsm_pkg::C_RINIT:   state_next = fcsm_pkg::S_RI;
            fcsm_pkg::C_GETSTAT: state_next = fcsm_pkg::S_GSI;
            default: ok = 1'b0;
          endcase
        end
        fcsm_pkg::S_RI: begin
          if (code == fcsm_pkg::C_NULL) begin
            ok = 1'b1;
            status_word_next = fcsm_pkg::ST_READ;
            state_next       = fcsm_pkg::S_RRS1;
            read_mode_next   = 1'b1;
          end else if (code == fcsm_pkg::C_RINIT) begin
            ok = 1'b1;
          end else begin
            read_mode_next = 1'b0;
          end
        end
        fcsm_pkg::S_RRS1: begin
          if (code == fcsm_pkg::C_NULL) begin
            ok = 1'b1;
            status_word_next = fcsm_pkg::ST_READ2;
            state_next       = fcsm_pkg::S_IDLE;
          end else if (code == fcsm_pkg::C_RINIT) begin
            ok = 1'b1;
          end else begin
            read_mode_next = 1'b0;
            if (code == fcsm_pkg::C_ERASE1) begin
              ok = 1'b1;
              page_next  = cmd_page;
              state_next = fcsm_pkg::S_E1;
            end
          end
        end
        default: ok = 1'b0;
      endcase
      // Drop to idle on any event the sequence does not allow.
      if (!ok) begin
        state_next = fcsm_pkg::S_IDLE;
      end
    end
  end

  // Outputs
  always_comb begin
    rsp_next = '0;
    if (run_step) begin
      rsp_next.error = !ok;
      case (state)
        fcsm_pkg::S_E2, fcsm_pkg::S_ERS2: begin
          if (code == fcsm_pkg::C_EXEC) begin
            rsp_next.action      = fcsm_pkg::ACT_ERASE;
            rsp_next.action_page = page;
          end
        end
        fcsm_pkg::S_WRS2: begin
          if (code == fcsm_pkg::C_EXEC) begin
            rsp_next.action      = fcsm_pkg::ACT_PROGRAM;
            rsp_next.action_page = page;
          end
        end
        fcsm_pkg::S_RI, fcsm_pkg::S_RRS1: begin
          if (code == fcsm_pkg::C_NULL) begin
            rsp_next.action = fcsm_pkg::ACT_DUMP;
          end
        end
        default: rsp_next.action = fcsm_pkg::ACT_NONE;
      endcase
    end
    if (in_word.opcode == fcsm_pkg::OP_STATUS_READ) begin
      if (read_mode) begin
        rsp_next.status_data = shadow_status;
      end else if (ok) begin
        rsp_next.status_data = status_word_next;
      end else begin
        rsp_next.status_data = fcsm_pkg::ST_TWO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= fcsm_pkg::S_IDLE;
      status_word   <= fcsm_pkg::ST_GET;
      shadow_status <= '0;
      page          <= '0;
      read_mode     <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (advance) begin
        rsp_valid <= in_valid;
      end
      if (fire) begin
        state         <= state_next;
        status_word   <= status_word_next;
        shadow_status <= shadow_status_next;
        page          <= page_next;
        read_mode     <= read_mode_next;
      end
    end
    if (fire) begin
      rsp <= rsp_next;
    end
  end

endmodule

@@ design/fcsm_check.sv @@
module fcsm_check (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input fcsm_pkg::cmd_t cmd,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input fcsm_pkg::rsp_t rsp
);

  // Hold a stalled result word.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("rsp word changed while stalled");

  // Erase and program come from command writes, which carry no status.
  a_action_no_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.action == fcsm_pkg::ACT_ERASE ||
                  rsp.action == fcsm_pkg::ACT_PROGRAM) |-> rsp.status_data == '0)
    else $error("page action with nonzero status");

  a_page_only_with_page_action: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.action == fcsm_pkg::ACT_NONE ||
                  rsp.action == fcsm_pkg::ACT_DUMP) |-> rsp.action_page == '0)
    else $error("page reported without a page action");

  a_error_no_action: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.error |-> rsp.action == fcsm_pkg::ACT_NONE)
    else $error("action reported on a rejected event");

  a_error_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.error && rsp.status_data != '0 |->
      rsp.status_data == fcsm_pkg::ST_TWO)
    else $error("rejected status read with wrong status word");

endmodule

bind flash_command_state_machine fcsm_check u_fcsm_check (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
